/* sv/vna_pkg.sv */
// Package: types, constants and state encoding for the vertex normal accumulator.
package vna_pkg;

    localparam int VertexMax   = 4096;
    localparam int IdxW        = 12;
    localparam int PosW        = 16;
    localparam int SumW        = 40;
    localparam int OneQ14      = 16384;
    localparam int LimitReset  = 7;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TRI   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]             operation;
        logic [IdxW-1:0]        vertex_a;
        logic [IdxW-1:0]        vertex_b;
        logic [IdxW-1:0]        vertex_c;
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] pos_z;
    } t_in_word;

    typedef struct packed {
        logic [IdxW-1:0]        vertex_index;
        logic signed [15:0]     normal_x;
        logic signed [15:0]     normal_y;
        logic signed [15:0]     normal_z;
        logic                   degenerate;
        logic                   saturated;
    } t_out_word;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TRI_RD_A,
        ST_TRI_RD_B,
        ST_TRI_RD_C,
        ST_TRI_EDGE,
        ST_TRI_MUL,
        ST_TRI_SUB,
        ST_TRI_SUM_RD,
        ST_TRI_SUM_WR,
        ST_RD_SUM,
        ST_RD_MAG,
        ST_RD_SHIFT,
        ST_RD_SQ,
        ST_RD_ADD,
        ST_RD_SQRT,
        ST_RD_DIV,
        ST_RD_OUT
    } t_state;

endpackage

/* sv/vertex_normal_accumulator.sv */
// Top level: vertex position and normal sum memories with their sequencer.
//
// Usage: drive the input word and pulse i_start while o_busy is low. The word
// is taken at that edge. Load (0) stores a position and clears the vertex sum,
// triangle (1) adds the edge cross product to the sums of its three corners,
// read (2) returns the unit normal of one vertex as a single-cycle o_valid
// pulse on o_result; operation 3 is dropped.
// A load leaves o_busy low; a triangle keeps o_busy high through three position
// reads, edges, products, differences, then one sum read-modify-write per
// corner on the single sum port. A read puts its word out after the sum read,
// magnitude, shift, square and add steps, a 32-step bit-serial square root
// and three restoring divides that share one divider; a read whose sum is
// too short skips the square root and the divides.
// o_busy is high during a triangle or read; one item is in flight at a time.
// Reset clears the sequencer and sets degenerate_limit to 7; memory contents
// are undefined until each vertex is loaded. The receiver cannot stall:
// o_valid marks each result, and o_result holds it until the next read result.
// degenerate_limit sits at APB address 0.
module vertex_normal_accumulator #(
    parameter int MAX_VERTICES = vna_pkg::VertexMax
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  vna_pkg::t_in_word  i_word,
    output logic               o_busy,
    output logic               o_valid,
    output vna_pkg::t_out_word o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import vna_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int QW = 32;

    // ---------------- configuration
    logic [15:0] r_limit;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, r_limit} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 16'(LimitReset);
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_limit <= pwdata[15:0];
        end
    end

    // ---------------- memories
    logic [3*PosW-1:0]  pos_mem [MAX_VERTICES];
    logic [3*SumW:0]    sum_mem [MAX_VERTICES];
    logic               pos_we, sum_we;
    logic [AW-1:0]      pos_waddr, pos_raddr, sum_addr;
    logic [3*PosW-1:0]  pos_wdata, pos_rdata;
    logic [3*SumW:0]    sum_wdata, sum_rdata;

    always_ff @(posedge i_clk) begin
        if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
        pos_rdata <= pos_mem[pos_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (sum_we) sum_mem[sum_addr] <= sum_wdata;
        sum_rdata <= sum_mem[sum_addr];
    end

    // ---------------- registers
    t_state                    r_state, n_state;
    t_in_word                  r_word;
    logic [1:0]                r_corner;
    logic signed [PosW-1:0]    r_pa [3];
    logic signed [PosW-1:0]    r_pb [3];
    logic signed [PosW:0]      r_e1 [3];
    logic signed [PosW:0]      r_e2 [3];
    logic signed [2*PosW+1:0]  r_pr [6];
    logic signed [2*PosW+2:0]  r_n  [3];
    logic [SumW-1:0]           r_mag [3];
    logic [2:0]                r_neg;
    logic                      r_sat;
    logic [3:0]                r_sh;
    logic [63:0]               r_sq [3];
    logic [63:0]               r_res;
    logic [63:0]               r_rem;
    logic [31:0]               r_root;
    logic [5:0]                r_cnt;
    logic [1:0]                r_k;
    logic [QW+14:0]            r_dnum;
    logic [QW:0]               r_drem;
    logic [15:0]               r_q [3];
    logic                      r_degen;
    logic                      r_valid;
    t_out_word                 r_out;

    logic accept;
    logic in_range_a, tri_ok;
    assign accept = i_start && (r_state == ST_IDLE);
    assign in_range_a = 32'(i_word.vertex_a) < 32'(MAX_VERTICES);
    assign tri_ok = in_range_a && 32'(i_word.vertex_b) < 32'(MAX_VERTICES)
                  && 32'(i_word.vertex_c) < 32'(MAX_VERTICES);
    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    // ---------------- combinational helpers
    logic [AW-1:0] corner_addr;
    always_comb begin
        case (r_corner)
            2'd0:    corner_addr = r_word.vertex_a[AW-1:0];
            2'd1:    corner_addr = r_word.vertex_b[AW-1:0];
            default: corner_addr = r_word.vertex_c[AW-1:0];
        endcase
    end

    logic signed [SumW-1:0] cur [3];
    logic signed [SumW+1:0] s_add [3];
    logic [3*SumW:0]        acc_word;
    logic                   acc_sat;
    always_comb begin
        acc_sat = sum_rdata[3*SumW];
        for (int k = 0; k < 3; k++) begin
            cur[k] = sum_rdata[k*SumW +: SumW];
            s_add[k] = (SumW+2)'(cur[k]) + (SumW+2)'(r_n[k]);
            if (s_add[k] > (SumW+2)'(signed'({2'b00, {(SumW-1){1'b1}}}))) begin
                s_add[k] = (SumW+2)'(signed'({3'b000, {(SumW-1){1'b1}}}));
                acc_sat = 1'b1;
            end else if (s_add[k] < -(SumW+2)'(signed'({2'b01, {(SumW-1){1'b0}}}))) begin
                s_add[k] = -(SumW+2)'(signed'({2'b01, {(SumW-1){1'b0}}}));
                acc_sat = 1'b1;
            end
        end
        acc_word = {acc_sat, s_add[2][SumW-1:0], s_add[1][SumW-1:0], s_add[0][SumW-1:0]};
    end

    logic [SumW-1:0] mx;
    logic [3:0]      sh_need;
    always_comb begin
        mx = r_mag[0];
        if (r_mag[1] > mx) mx = r_mag[1];
        if (r_mag[2] > mx) mx = r_mag[2];
        sh_need = 4'd0;
        for (int s = 1; s <= 9; s++) begin
            if ((mx >> (s - 1)) >= (SumW)'(64'h8000_0000)) sh_need = 4'(s);
        end
    end

    // sqrt step
    logic [63:0] sq_sum, sq_bit, sq_trial, sq_next;
    assign sq_sum   = r_sq[0] + r_sq[1] + r_sq[2];
    assign sq_bit   = 64'd1 << {r_cnt[4:0], 1'b0};
    assign sq_trial = r_res + sq_bit;
    assign sq_next  = (r_rem >= sq_trial) ? ((r_res >> 1) + sq_bit) : (r_res >> 1);

    // divide step (restoring, one bit per cycle)
    logic [QW:0] d_try;
    assign d_try = {r_drem[QW-1:0], r_dnum[QW+14]};

    always_comb begin
        n_state   = r_state;
        pos_we    = 1'b0;
        pos_waddr = i_word.vertex_a[AW-1:0];
        pos_wdata = {i_word.pos_z, i_word.pos_y, i_word.pos_x};
        pos_raddr = corner_addr;
        sum_we    = 1'b0;
        sum_addr  = corner_addr;
        sum_wdata = acc_word;
        unique case (r_state)
            ST_IDLE: begin
                sum_addr  = i_word.vertex_a[AW-1:0];
                sum_wdata = '0;
                if (accept) begin
                    unique case (t_op'(i_word.operation))
                        OP_LOAD: begin
                            pos_we = in_range_a;
                            sum_we = in_range_a;
                        end
                        OP_TRI:  if (tri_ok) n_state = ST_TRI_RD_A;
                        OP_READ: n_state = in_range_a ? ST_RD_SUM : ST_RD_OUT;
                        OP_NONE: n_state = ST_IDLE;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TRI_RD_A:   n_state = ST_TRI_RD_B;
            ST_TRI_RD_B:   n_state = ST_TRI_RD_C;
            ST_TRI_RD_C:   n_state = ST_TRI_EDGE;
            ST_TRI_EDGE:   n_state = ST_TRI_MUL;
            ST_TRI_MUL:    n_state = ST_TRI_SUB;
            ST_TRI_SUB:    n_state = ST_TRI_SUM_RD;
            ST_TRI_SUM_RD: n_state = ST_TRI_SUM_WR;
            ST_TRI_SUM_WR: begin
                sum_we  = 1'b1;
                n_state = (r_corner == 2'd2) ? ST_IDLE : ST_TRI_SUM_RD;
            end
            ST_RD_SUM: begin
                sum_addr = r_word.vertex_a[AW-1:0];
                n_state  = ST_RD_MAG;
            end
            ST_RD_MAG:   n_state = ST_RD_SHIFT;
            ST_RD_SHIFT: n_state = ST_RD_SQ;
            ST_RD_SQ:    n_state = ST_RD_ADD;
            ST_RD_ADD: begin
                if (r_sh == 4'd0 && sq_sum <= 64'(r_limit) * 64'(r_limit)) begin
                    n_state = ST_RD_OUT;
                end else begin
                    n_state = ST_RD_SQRT;
                end
            end
            ST_RD_SQRT: begin
                if (r_cnt == 6'd0) n_state = ST_RD_DIV;
            end
            ST_RD_DIV: begin
                if (r_root == 32'd0) begin
                    n_state = ST_RD_OUT;
                end else if (r_cnt == 6'd0 && r_k == 2'd2) begin
                    n_state = ST_RD_OUT;
                end
            end
            ST_RD_OUT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_RD_OUT);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_word   <= i_word;
                r_corner <= 2'd0;
                r_sat    <= 1'b0;
                r_degen  <= 1'b1;
                r_root   <= 32'd0;
            end
            ST_TRI_RD_A: r_corner <= 2'd1;
            ST_TRI_RD_B: begin
                r_corner <= 2'd2;
                for (int k = 0; k < 3; k++) r_pa[k] <= pos_rdata[k*PosW +: PosW];
            end
            ST_TRI_RD_C: begin
                for (int k = 0; k < 3; k++) r_pb[k] <= pos_rdata[k*PosW +: PosW];
            end
            ST_TRI_EDGE: begin
                r_corner <= 2'd0;
                for (int k = 0; k < 3; k++) begin
                    r_e1[k] <= (PosW+1)'(r_pb[k]) - (PosW+1)'(r_pa[k]);
                    r_e2[k] <= (PosW+1)'(signed'(pos_rdata[k*PosW +: PosW]))
                             - (PosW+1)'(r_pa[k]);
                end
            end
            ST_TRI_MUL: begin
                r_pr[0] <= r_e1[1] * r_e2[2];
                r_pr[1] <= r_e1[2] * r_e2[1];
                r_pr[2] <= r_e1[2] * r_e2[0];
                r_pr[3] <= r_e1[0] * r_e2[2];
                r_pr[4] <= r_e1[0] * r_e2[1];
                r_pr[5] <= r_e1[1] * r_e2[0];
            end
            ST_TRI_SUB: begin
                for (int k = 0; k < 3; k++) begin
                    r_n[k] <= (2*PosW+3)'(r_pr[2*k]) - (2*PosW+3)'(r_pr[2*k+1]);
                end
            end
            ST_TRI_SUM_WR: r_corner <= r_corner + 2'd1;
            ST_RD_MAG: begin
                r_sat <= sum_rdata[3*SumW];
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= sum_rdata[k*SumW + SumW - 1];
                    r_mag[k] <= sum_rdata[k*SumW + SumW - 1]
                              ? SumW'(-sum_rdata[k*SumW +: SumW])
                              : sum_rdata[k*SumW +: SumW];
                end
            end
            ST_RD_SHIFT: begin
                r_sh <= sh_need;
                for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> sh_need;
            end
            ST_RD_SQ: begin
                for (int k = 0; k < 3; k++) begin
                    r_sq[k] <= 64'(r_mag[k][31:0]) * 64'(r_mag[k][31:0]);
                end
            end
            ST_RD_ADD: begin
                r_rem  <= sq_sum;
                r_res  <= 64'd0;
                r_root <= 32'd0;
                r_cnt  <= 6'd31;
            end
            ST_RD_SQRT: begin
                if (r_rem >= sq_trial) r_rem <= r_rem - sq_trial;
                r_res <= sq_next;
                if (r_cnt == 6'd0) begin
                    r_root <= sq_next[31:0];
                    r_k    <= 2'd0;
                    r_cnt  <= 6'(QW + 15);
                    r_drem <= '0;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
            ST_RD_DIV: begin
                if (r_cnt == 6'(QW + 15)) begin
                    // numerator = mag * 16384 + len/2
                    r_dnum <= (QW+15)'({r_mag[r_k][31:0], 14'd0})
                            + (QW+15)'(r_root >> 1);
                    r_drem <= '0;
                    r_cnt  <= r_cnt - 6'd1;
                end else begin
                    r_dnum <= {r_dnum[QW+13:0], (d_try >= {1'b0, r_root})};
                    r_drem <= (d_try >= {1'b0, r_root}) ? d_try - {1'b0, r_root} : d_try;
                    if (r_cnt == 6'd0) begin
                        r_q[r_k] <= 16'(({r_dnum[QW+13:0], (d_try >= {1'b0, r_root})}
                                   > (QW+15)'(OneQ14)) ? (QW+15)'(OneQ14)
                                   : {r_dnum[QW+13:0], (d_try >= {1'b0, r_root})});
                        r_k   <= r_k + 2'd1;
                        r_cnt <= 6'(QW + 15);
                        if (r_k == 2'd2) r_degen <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
            end
            ST_RD_OUT: begin
                r_out.vertex_index <= r_word.vertex_a;
                r_out.saturated    <= r_sat;
                r_out.degenerate   <= r_degen;
                if (r_degen) begin
                    r_out.normal_x <= '0;
                    r_out.normal_y <= 16'(OneQ14);
                    r_out.normal_z <= '0;
                end else begin
                    r_out.normal_x <= r_neg[0] ? -r_q[0] : r_q[0];
                    r_out.normal_y <= r_neg[1] ? -r_q[1] : r_q[1];
                    r_out.normal_z <= r_neg[2] ? -r_q[2] : r_q[2];
                end
            end
            default: ;
        endcase
    end

    // ---------------- assertions
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !(r_state == ST_IDLE)) else $error("busy outside item");
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result held two cycles");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == ST_IDLE) else $error("result while busy");
    a_degen_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.degenerate |-> o_result.normal_y == 16'(OneQ14))
        else $error("degenerate without up vector");
    a_sum_wr_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TRI_SUM_WR |-> $past(r_state) == ST_TRI_SUM_RD)
        else $error("sum write without read");

endmodule
